[design/mmpid_pkg.sv]
`timescale 1ns / 1ps

package mmpid_pkg;

  localparam int DATA_W       = 32;
  localparam int FRAC_W       = 16;
  localparam int LIMIT_W      = 31;
  localparam int MODE_W       = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int SMOOTH_W     = 17;
  localparam int SMOOTH_SHIFT = 16;
  // second-difference error tap needs two bits over the data width
  localparam int B_W          = DATA_W + 2;
  localparam int PROD_W       = DATA_W + B_W;
  localparam int ACC_W        = 56;
  localparam int PC_W         = 4;

  localparam logic [SMOOTH_W-1:0] SMOOTH_ONE = SMOOTH_W'(65536);
  localparam logic [LIMIT_W-1:0]  LIMIT_MAX  = '1;

  localparam logic [MODE_W-1:0] MODE_INC_PID   = 4'd0;
  localparam logic [MODE_W-1:0] MODE_INC_PD    = 4'd1;
  localparam logic [MODE_W-1:0] MODE_POS_PID   = 4'd2;
  localparam logic [MODE_W-1:0] MODE_POS_PD    = 4'd3;
  localparam logic [MODE_W-1:0] MODE_MEAS_PID  = 4'd4;
  localparam logic [MODE_W-1:0] MODE_MEAS_PD   = 4'd5;
  localparam logic [MODE_W-1:0] MODE_FLT_PID   = 4'd6;
  localparam logic [MODE_W-1:0] MODE_FLT_PD    = 4'd7;
  localparam logic [MODE_W-1:0] MODE_FLT_CLAMP = 4'd8;
  localparam logic [MODE_W-1:0] MODE_RESET     = MODE_POS_PID;

  // program addresses
  localparam logic [PC_W-1:0] PC_ENTRY = 4'd0;
  localparam logic [PC_W-1:0] PC_SUM   = 4'd4;
  localparam logic [PC_W-1:0] PC_OUT   = 4'd5;
  localparam logic [PC_W-1:0] PC_INC   = 4'd6;
  localparam logic [PC_W-1:0] PC_FLT   = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE,
    REG_KP,
    REG_KI,
    REG_KD,
    REG_ILIM,
    REG_DLIM,
    REG_OLIM
  } cfg_reg_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_t;

  typedef enum logic [2:0] {
    A_KP,
    A_KI,
    A_KD,
    A_FILT,
    A_MEAS
  } a_sel_t;

  typedef enum logic [2:0] {
    B_ESUM,
    B_DERIV,
    B_PROP,
    B_SMOOTH,
    B_SMOOTH_C
  } b_sel_t;

  typedef enum logic [2:0] {
    ACC_NOP,
    ACC_START,
    ACC_ADDQ,
    ACC_LOADP,
    ACC_ADDP,
    ACC_SUM,
    ACC_DRIVE
  } acc_op_t;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_ALWAYS,
    JMP_IF_INCR,
    JMP_IF_FILT
  } jmp_t;

  typedef struct packed {
    a_sel_t            a_sel;
    b_sel_t            b_sel;
    acc_op_t           acc_op;
    logic              wr_int;
    logic              wr_filt;
    logic              ld_d;
    logic              done;
    jmp_t              jmp;
    logic [PC_W-1:0]   target;
  } ctrl_t;

  typedef struct packed {
    ctrl_t ctrl;
    logic  start;
    logic  commit;
  } seq_ctl_t;

  typedef struct packed {
    logic incr;
    logic with_i;
    logic filt;
    logic meas_d;
    logic out_clamp;
    logic upd_meas;
  } mode_flags_t;

  typedef struct packed {
    mode_flags_t               flags;
    logic signed [DATA_W-1:0]  kp;
    logic signed [DATA_W-1:0]  ki;
    logic signed [DATA_W-1:0]  kd;
    logic [LIMIT_W-1:0]        ilim;
    logic [LIMIT_W-1:0]        dlim;
    logic [LIMIT_W-1:0]        olim;
  } cfg_t;

  function automatic mode_flags_t decode_mode(input logic [MODE_W-1:0] m);
    mode_flags_t f;
    f.incr      = m inside {MODE_INC_PID, MODE_INC_PD};
    f.with_i    = !m[0];
    f.filt      = m inside {MODE_FLT_PID, MODE_FLT_PD, MODE_FLT_CLAMP};
    f.meas_d    = m inside {MODE_MEAS_PID, MODE_MEAS_PD};
    f.out_clamp = (m == MODE_FLT_CLAMP);
    f.upd_meas  = m inside {MODE_MEAS_PID, MODE_MEAS_PD, MODE_FLT_PID, MODE_FLT_CLAMP};
    return f;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_dw(input logic signed [ACC_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (&v[ACC_W-1:DATA_W-1] || ~|v[ACC_W-1:DATA_W-1]) begin
      r = v[DATA_W-1:0];
    end else if (v[ACC_W-1]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp_sym(input logic signed [DATA_W-1:0] v,
                                                         input logic [LIMIT_W-1:0] lim);
    logic signed [DATA_W-1:0] lim_s;
    logic signed [DATA_W-1:0] r;
    lim_s = signed'({1'b0, lim});
    if (v > lim_s) begin
      r = lim_s;
    end else if (v < -lim_s) begin
      r = -lim_s;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // microprogram: operands picked at a step pass through opa/opb, then prod
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t c;
    c = '0;
    case (pc)
      4'd0: begin
        c.a_sel = A_KI;  c.b_sel = B_ESUM;
        c.jmp = JMP_IF_FILT; c.target = PC_FLT;
      end
      4'd1: begin
        c.a_sel = A_KD;  c.b_sel = B_DERIV;
      end
      4'd2: begin
        c.a_sel = A_KP;  c.b_sel = B_PROP;
        c.acc_op = ACC_START;
      end
      4'd3: begin
        c.acc_op = ACC_ADDQ; c.wr_int = 1'b1; c.ld_d = 1'b1;
        c.jmp = JMP_IF_INCR; c.target = PC_INC;
      end
      4'd4: begin
        c.acc_op = ACC_SUM;
      end
      4'd5: begin
        c.done = 1'b1;
      end
      4'd6: begin
        c.acc_op = ACC_ADDQ;
      end
      4'd7: begin
        c.acc_op = ACC_DRIVE;
        c.jmp = JMP_ALWAYS; c.target = PC_OUT;
      end
      4'd8: begin
        c.a_sel = A_FILT; c.b_sel = B_SMOOTH;
      end
      4'd9: begin
        c.a_sel = A_MEAS; c.b_sel = B_SMOOTH_C;
        c.acc_op = ACC_START;
      end
      4'd10: begin
        c.wr_int = 1'b1; c.acc_op = ACC_LOADP;
      end
      4'd11: begin
        c.acc_op = ACC_ADDP;
      end
      4'd12: begin
        c.wr_filt = 1'b1;
      end
      4'd13: begin
        c.a_sel = A_KD;  c.b_sel = B_DERIV;
      end
      4'd14: begin
        c.a_sel = A_KP;  c.b_sel = B_PROP;
      end
      4'd15: begin
        c.ld_d = 1'b1;
        c.jmp = JMP_ALWAYS; c.target = PC_SUM;
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

[design/mmpid_if.sv]
`timescale 1ns / 1ps

interface mmpid_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [mmpid_pkg::DATA_W-1:0]    target;
  logic signed [mmpid_pkg::DATA_W-1:0]    measured;
  logic [mmpid_pkg::SMOOTH_W-1:0]         smoothing;
  logic                                   clear;

  modport source (output valid, output target, output measured, output smoothing,
                  output clear, input ready);
  modport sink (input valid, input target, input measured, input smoothing,
                input clear, output ready);
endinterface

interface mmpid_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [mmpid_pkg::DATA_W-1:0]    drive;

  modport source (output valid, output drive, input ready);
  modport sink (input valid, input drive, output ready);
endinterface

[design/mmpid_seq.sv]
`timescale 1ns / 1ps

module mmpid_seq (
  input  logic                   clk,
  input  logic                   rst,
  input  mmpid_pkg::mode_flags_t flags,
  input  logic                   in_valid,
  input  logic                   in_clear,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output mmpid_pkg::seq_ctl_t    ctl
);
  import mmpid_pkg::*;

  seq_state_t      state, state_next;
  logic [PC_W-1:0] pc, pc_next;
  ctrl_t           word;
  logic            accept;
  logic            advance;
  logic            commit;
  logic            take;

  assign word = ucode(pc);

  // the last step waits while the previous result is still held
  assign advance = !word.done || !out_valid || out_ready;

  always_comb begin
    case (word.jmp)
      JMP_ALWAYS:  take = 1'b1;
      JMP_IF_INCR: take = flags.incr;
      JMP_IF_FILT: take = flags.filt;
      default:     take = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_RUN;
      ST_RUN:  if (commit) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state == ST_IDLE) && !rst;
    accept     = in_valid && in_ready;
    commit     = (state == ST_RUN) && word.done && advance;
    ctl.ctrl   = (state == ST_RUN) ? word : '0;
    ctl.start  = accept;
    ctl.commit = commit;
  end

  always_comb begin
    pc_next = pc;
    if (accept) begin
      pc_next = in_clear ? PC_OUT : PC_ENTRY;
    end else if (state == ST_RUN && advance) begin
      if (word.done) begin
        pc_next = PC_ENTRY;
      end else if (take) begin
        pc_next = word.target;
      end else begin
        pc_next = pc + PC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pc        <= PC_ENTRY;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[design/mmpid_dp.sv]
`timescale 1ns / 1ps

module mmpid_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  mmpid_pkg::seq_ctl_t                 ctl,
  input  mmpid_pkg::cfg_t                     cfg,
  input  logic signed [mmpid_pkg::DATA_W-1:0] target,
  input  logic signed [mmpid_pkg::DATA_W-1:0] measured,
  input  logic [mmpid_pkg::SMOOTH_W-1:0]      smoothing,
  input  logic                                clear,
  output logic signed [mmpid_pkg::DATA_W-1:0] drive
);
  import mmpid_pkg::*;

  // item registers
  logic signed [DATA_W-1:0] e_reg;
  logic signed [DATA_W-1:0] m_reg;
  logic [SMOOTH_W-1:0]      s_reg;
  logic                     clr_reg;

  // controller state
  logic signed [DATA_W-1:0] acc_drive;
  logic signed [DATA_W-1:0] last_error;
  logic signed [DATA_W-1:0] older_error;
  logic signed [DATA_W-1:0] last_measured;
  logic signed [DATA_W-1:0] integral_sum;
  logic signed [DATA_W-1:0] filtered_meas;
  logic signed [DATA_W-1:0] last_filtered;

  // shared arithmetic
  logic signed [DATA_W-1:0] opa, opa_next;
  logic signed [B_W-1:0]    opb, opb_next;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [DATA_W-1:0] d_reg;

  logic signed [DATA_W:0]   err_diff;
  logic signed [B_W-1:0]    e_x, e1_x, e2_x, lm_x, m_x, lf_x, fm_x;
  logic signed [B_W-1:0]    deriv_b, prop_b;
  logic signed [ACC_W-1:0]  prodq, prodr, int_x, d_x, drv_x;
  logic signed [DATA_W-1:0] acc_sat, prodq_sat, y;
  mode_flags_t              fl;

  assign fl = cfg.flags;

  assign err_diff = (DATA_W+1)'(target) - (DATA_W+1)'(measured);

  assign e_x  = B_W'(e_reg);
  assign e1_x = B_W'(last_error);
  assign e2_x = B_W'(older_error);
  assign lm_x = B_W'(last_measured);
  assign m_x  = B_W'(m_reg);
  assign lf_x = B_W'(last_filtered);
  assign fm_x = B_W'(filtered_meas);

  always_comb begin
    if (fl.incr) begin
      deriv_b = e_x - (e1_x <<< 1) + e2_x;
    end else if (fl.meas_d) begin
      deriv_b = lm_x - m_x;
    end else if (fl.filt) begin
      deriv_b = lf_x - fm_x;
    end else begin
      deriv_b = e_x - e1_x;
    end
    prop_b = fl.incr ? (e_x - e1_x) : e_x;
  end

  always_comb begin
    case (ctl.ctrl.a_sel)
      A_KP:    opa_next = cfg.kp;
      A_KI:    opa_next = cfg.ki;
      A_KD:    opa_next = cfg.kd;
      A_FILT:  opa_next = filtered_meas;
      A_MEAS:  opa_next = m_reg;
      default: opa_next = cfg.kp;
    endcase
    case (ctl.ctrl.b_sel)
      B_ESUM:     opb_next = e_x + e1_x;
      B_DERIV:    opb_next = deriv_b;
      B_PROP:     opb_next = prop_b;
      B_SMOOTH:   opb_next = B_W'(s_reg);
      B_SMOOTH_C: opb_next = B_W'(SMOOTH_ONE - s_reg);
      default:    opb_next = prop_b;
    endcase
  end

  // product scaled back to the fraction point, rounding toward minus infinity
  assign prodq     = ACC_W'(prod >>> FRAC_W);
  assign prodr     = ACC_W'(prod);
  assign int_x     = ACC_W'(integral_sum);
  assign d_x       = ACC_W'(d_reg);
  assign drv_x     = ACC_W'(acc_drive);
  assign acc_sat   = sat_dw(acc);
  assign prodq_sat = sat_dw(prodq);

  always_comb begin
    if (clr_reg) begin
      y = '0;
    end else if (fl.out_clamp) begin
      y = clamp_sym(acc_sat, cfg.olim);
    end else begin
      y = acc_sat;
    end
  end

  always_ff @(posedge clk) begin
    opa  <= opa_next;
    opb  <= opb_next;
    prod <= PROD_W'(opa) * PROD_W'(opb);

    if (ctl.start) begin
      e_reg   <= sat_dw(ACC_W'(err_diff));
      m_reg   <= measured;
      s_reg   <= (smoothing > SMOOTH_ONE) ? SMOOTH_ONE : smoothing;
      clr_reg <= clear;
    end

    case (ctl.ctrl.acc_op)
      ACC_START: acc <= (fl.with_i ? prodq : '0) + (fl.incr ? '0 : int_x);
      ACC_ADDQ:  acc <= acc + prodq;
      ACC_LOADP: acc <= prodr;
      ACC_ADDP:  acc <= acc + prodr;
      ACC_SUM:   acc <= prodq + d_x + (fl.with_i ? int_x : '0);
      ACC_DRIVE: acc <= ACC_W'(acc_sat) + drv_x;
      default:   acc <= acc;
    endcase

    if (ctl.ctrl.ld_d) begin
      d_reg <= fl.filt ? clamp_sym(prodq_sat, cfg.dlim) : prodq_sat;
    end

    if (ctl.commit) begin
      drive <= y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_drive     <= '0;
      last_error    <= '0;
      older_error   <= '0;
      last_measured <= '0;
      integral_sum  <= '0;
      filtered_meas <= '0;
      last_filtered <= '0;
    end else if (ctl.commit && clr_reg) begin
      acc_drive     <= '0;
      last_error    <= '0;
      older_error   <= '0;
      last_measured <= '0;
      integral_sum  <= '0;
      filtered_meas <= '0;
      last_filtered <= '0;
    end else begin
      if (ctl.ctrl.wr_int && fl.with_i && !fl.incr) begin
        integral_sum <= clamp_sym(acc_sat, cfg.ilim);
      end
      if (ctl.ctrl.wr_filt) begin
        filtered_meas <= sat_dw(acc >>> SMOOTH_SHIFT);
      end
      if (ctl.commit) begin
        acc_drive  <= y;
        last_error <= e_reg;
        if (fl.incr) older_error <= last_error;
        if (fl.upd_meas) last_measured <= m_reg;
        if (fl.filt) last_filtered <= filtered_meas;
      end
    end
  end

endmodule

[design/multi_mode_pid_controller.sv]
`timescale 1ns / 1ps
// an item runs a microprogram per mode: incremental (modes 0,1), positional (modes 2..5)
// or filtered (modes 6..8); a clear item runs only the final step
// one item in flight; the next can be taken once the result is registered; all programs
// run around one shared 32x34 multiplier; a result left waiting holds only the final step
// synchronous reset: mode 2, gains 0, limits at full scale, all controller state zero

module multi_mode_pid_controller (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [mmpid_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mmpid_pkg::DATA_W-1:0]         cfg_data,
  mmpid_in_if.sink                             sample,
  mmpid_out_if.source                          result
);
  import mmpid_pkg::*;

  logic [MODE_W-1:0]        mode;
  logic signed [DATA_W-1:0] kp_gain;
  logic signed [DATA_W-1:0] ki_half_dt;
  logic signed [DATA_W-1:0] kd_over_dt;
  logic [LIMIT_W-1:0]       integral_limit;
  logic [LIMIT_W-1:0]       derivative_limit;
  logic [LIMIT_W-1:0]       drive_limit;

  cfg_t     cfg;
  seq_ctl_t ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_RESET;
      kp_gain          <= '0;
      ki_half_dt       <= '0;
      kd_over_dt       <= '0;
      integral_limit   <= LIMIT_MAX;
      derivative_limit <= LIMIT_MAX;
      drive_limit      <= LIMIT_MAX;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_MODE: begin
          // out-of-range mode codes are dropped
          if (cfg_data[MODE_W-1:0] <= MODE_FLT_CLAMP) mode <= cfg_data[MODE_W-1:0];
        end
        REG_KP:   kp_gain          <= signed'(cfg_data);
        REG_KI:   ki_half_dt       <= signed'(cfg_data);
        REG_KD:   kd_over_dt       <= signed'(cfg_data);
        REG_ILIM: integral_limit   <= cfg_data[LIMIT_W-1:0];
        REG_DLIM: derivative_limit <= cfg_data[LIMIT_W-1:0];
        REG_OLIM: drive_limit      <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.flags = decode_mode(mode);
    cfg.kp    = kp_gain;
    cfg.ki    = ki_half_dt;
    cfg.kd    = kd_over_dt;
    cfg.ilim  = integral_limit;
    cfg.dlim  = derivative_limit;
    cfg.olim  = drive_limit;
  end

  mmpid_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .flags     (cfg.flags),
    .in_valid  (sample.valid),
    .in_clear  (sample.clear),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .ctl       (ctl)
  );

  mmpid_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .cfg       (cfg),
    .target    (sample.target),
    .measured  (sample.measured),
    .smoothing (sample.smoothing),
    .clear     (sample.clear),
    .drive     (result.drive)
  );

endmodule
